### sv/cqd_pkg.sv
// Shared types and constants for the counting quotient dictionary.
package cqd_pkg;
  localparam int CAPACITY_DEF = 32;
  localparam int REM_BITS_DEF = 8;
  localparam int CTR_BITS_DEF = 4;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_SPARE  = 2'd3;  // unused code, behaves as a lookup

  localparam logic [2:0] ST_EXISTING = 3'd0;
  localparam logic [2:0] ST_NEW      = 3'd1;
  localparam logic [2:0] ST_ABSENT   = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE, S_PREFIX, S_SEARCH, S_DECIDE, S_SHIFT, S_UPDATE, S_OUT
  } state_t;
endpackage

### sv/counting_quotient_dictionary.sv
// Top level of the counting quotient dictionary.
// One item at a time. A transfer on the input channel starts a walk: the bucket
// counts are read from quotient 0 up to the quotient and summed, the bucket is
// scanned in ascending order (each entry is read, then compared, and a scan that
// runs off the end of the bucket takes a final check), a decide step picks the
// outcome, then an insert or a delete moves the tail of the packed store one
// entry per cycle after a read-ahead, and the bucket count is updated last.
// Lookups, count updates, misses and full or overflow answers skip the tail move
// and the bucket update. The result sits in an output register until its
// transfer; the next item is taken after that.
// The bucket count memory is cleared by a sweep over all CAPACITY entries after
// reset, during which no input is taken. A quotient at or above CAPACITY is
// answered as not found without touching the store; operation code 3 acts as a
// lookup.
module counting_quotient_dictionary import cqd_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int REM_BITS = REM_BITS_DEF,
  parameter int CTR_BITS = CTR_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] operation,
  input  logic [4:0] quotient,
  input  logic [7:0] remainder,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       found,
  output logic [3:0] multiplicity,
  output logic [2:0] status,
  output logic [5:0] occupancy
);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int RB = (REM_BITS < 8) ? REM_BITS : 8;

  // bucket counts, packed remainders and counters
  logic [CW-1:0]       bmem [CAPACITY];
  logic [REM_BITS-1:0] rmem [CAPACITY];
  logic [CTR_BITS-1:0] cmem [CAPACITY];

  logic [CW-1:0]       b_rd;
  logic [REM_BITS-1:0] r_rd;
  logic [CTR_BITS-1:0] c_rd;
  logic [AW-1:0]       b_ra, e_ra, b_wa, e_wa;
  logic                b_we, e_we;
  logic [CW-1:0]       b_wd;
  logic [REM_BITS-1:0] r_wd;
  logic [CTR_BITS-1:0] c_wd;

  always_ff @(posedge clk) begin
    if (b_we) bmem[b_wa] <= b_wd;
    if (e_we) begin
      rmem[e_wa] <= r_wd;
      cmem[e_wa] <= c_wd;
    end
    b_rd <= bmem[b_ra];
    r_rd <= rmem[e_ra];
    c_rd <= cmem[e_ra];
  end

  state_t state, state_next;
  logic              clearing;
  logic [AW-1:0]     clr_idx;
  logic [1:0]        op;
  logic [AW-1:0]     q;
  logic [REM_BITS-1:0] r;
  logic [CW-1:0]     idx, lo, hi, total, pos, bcnt;
  logic              rd_pend, hit;
  logic [CTR_BITS-1:0] hit_cnt;
  logic              del;
  logic [CW-1:0]     sh;
  logic              sh_pend;
  logic [REM_BITS-1:0] car_r;
  logic [CTR_BITS-1:0] car_c;
  logic              go_shift, sh_first, sh_more, prefix_last;

  logic q_ok;
  assign q_ok = ({27'd0, quotient} < 32'(CAPACITY));
  assign in_ready = (state == S_IDLE) && !clearing;

  // a new entry or the removal of a last copy moves the tail of the store
  assign go_shift = (op == OP_INSERT && !hit && total < CW'(CAPACITY)) ||
                    (op == OP_REMOVE && hit && hit_cnt <= CTR_BITS'(1));
  // first move of the tail, and whether another follows the current one
  assign sh_first = del ? (sh + CW'(1) < total) : (sh <= total && sh < CW'(CAPACITY));
  assign sh_more  = del ? (sh + CW'(2) < total)
                        : (sh + CW'(1) <= total && sh + CW'(1) < CW'(CAPACITY));
  assign prefix_last = rd_pend && (idx == CW'(q) + CW'(1));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid && in_ready) state_next = q_ok ? S_PREFIX : S_OUT;
      S_PREFIX: if (prefix_last) state_next = S_SEARCH;
      S_SEARCH: if (!rd_pend && pos >= hi) state_next = S_DECIDE;
                else if (rd_pend && (r_rd >= r)) state_next = S_DECIDE;
      S_DECIDE: state_next = go_shift ? S_SHIFT : S_OUT;
      S_SHIFT:  if (sh_pend ? !sh_more : !sh_first) state_next = S_UPDATE;
      S_UPDATE: state_next = S_OUT;
      S_OUT:    if (out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    b_ra = clearing ? clr_idx : q;
    e_ra = pos[AW-1:0];
    b_we = clearing;
    b_wa = clr_idx;
    b_wd = '0;
    e_we = 1'b0;
    e_wa = pos[AW-1:0];
    r_wd = r;
    c_wd = hit_cnt;
    unique case (state)
      S_PREFIX: b_ra = idx[AW-1:0];
      S_SEARCH: e_ra = pos[AW-1:0];
      S_DECIDE: begin
        // count update in place
        if (hit && op == OP_INSERT && hit_cnt != '1) begin
          e_we = 1'b1; c_wd = hit_cnt + CTR_BITS'(1); r_wd = r;
        end else if (hit && op == OP_REMOVE && hit_cnt > CTR_BITS'(1)) begin
          e_we = 1'b1; c_wd = hit_cnt - CTR_BITS'(1); r_wd = r;
        end
      end
      S_SHIFT: begin
        // read the entry for the next write: one ahead of the written one on insert, two on delete
        if (del) e_ra = sh[AW-1:0] + (sh_pend ? AW'(2) : AW'(1));
        else     e_ra = sh[AW-1:0] + (sh_pend ? AW'(1) : AW'(0));
        if (sh_pend) begin
          e_we = 1'b1;
          if (del) begin
            e_wa = sh[AW-1:0]; r_wd = r_rd; c_wd = c_rd;
          end else begin
            e_wa = sh[AW-1:0]; r_wd = car_r; c_wd = car_c;
          end
        end
      end
      S_UPDATE: begin
        b_we = 1'b1; b_wa = q;
        b_wd = del ? bcnt - CW'(1) : bcnt + CW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; clearing <= 1'b1; clr_idx <= '0; total <= '0; out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_idx <= clr_idx + AW'(1);
        if (clr_idx == AW'(CAPACITY - 1)) clearing <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (in_valid && in_ready) begin
          op <= (operation == OP_SPARE) ? OP_LOOKUP : operation;
          q <= AW'(quotient);
          r <= REM_BITS'(remainder[RB-1:0]);
          idx <= '0; lo <= '0; rd_pend <= 1'b0; hit <= 1'b0; hit_cnt <= '0;
          found <= 1'b0; multiplicity <= '0; status <= ST_ABSENT;
          occupancy <= 6'(total);
          out_valid <= !q_ok;
        end
        S_PREFIX: begin
          // sum bucket counts below q, keep the count of q itself
          rd_pend <= !prefix_last;
          idx <= idx + CW'(1);
          if (rd_pend) begin
            if (prefix_last) begin
              bcnt <= b_rd; hi <= lo + b_rd; pos <= lo;
            end else lo <= lo + b_rd;
          end
        end
        S_SEARCH: begin
          if (!rd_pend) begin
            if (pos < hi) rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            if (r_rd == r) begin hit <= 1'b1; hit_cnt <= c_rd; end
            else if (r_rd < r) pos <= pos + CW'(1);
          end
        end
        S_DECIDE: begin
          found <= hit;
          out_valid <= !go_shift;
          del <= (op == OP_REMOVE);
          sh_pend <= 1'b0;
          car_r <= r; car_c <= CTR_BITS'(1);
          sh <= pos;
          if (op == OP_INSERT) begin
            if (hit) begin
              multiplicity <= 4'((hit_cnt == '1) ? hit_cnt : hit_cnt + CTR_BITS'(1));
              status <= (hit_cnt == '1) ? ST_OVERFLOW : ST_EXISTING;
            end else if (total >= CW'(CAPACITY)) status <= ST_FULL;
            else begin
              multiplicity <= 4'd1; status <= ST_NEW;
            end
          end else if (op == OP_REMOVE) begin
            if (hit) begin
              status <= ST_EXISTING;
              multiplicity <= 4'((hit_cnt > CTR_BITS'(1)) ? hit_cnt - CTR_BITS'(1) : '0);
            end
          end else if (hit) begin
            multiplicity <= 4'(hit_cnt); status <= ST_EXISTING;
          end
        end
        S_SHIFT: begin
          // insert: carry the displaced entry upward; delete: pull next down
          sh_pend <= sh_pend ? sh_more : sh_first;
          if (sh_pend) begin
            sh <= sh + CW'(1);
            if (!del) begin
              car_r <= r_rd; car_c <= c_rd;
            end
          end
        end
        S_UPDATE: begin
          total <= del ? total - CW'(1) : total + CW'(1);
          occupancy <= 6'(del ? total - CW'(1) : total + CW'(1));
          out_valid <= 1'b1;
        end
        S_OUT: if (out_ready) out_valid <= 1'b0;
        default: ;
      endcase
      if (state == S_DECIDE) occupancy <= 6'(total);
    end
  end
endmodule

### sv/cqd_checker.sv
// Port-level checker for the counting quotient dictionary, bound to the top.
module cqd_checker import cqd_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       found,
  input logic [3:0] multiplicity,
  input logic [2:0] status,
  input logic [5:0] occupancy
);
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_take_once: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("second input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result dropped");
  a_absent_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> multiplicity == 4'd0 || status == ST_NEW)
    else $error("absent item with count");
  a_new_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_NEW |-> !found && multiplicity == 4'd1 && occupancy != 6'd0)
    else $error("bad new entry result");
endmodule

bind counting_quotient_dictionary cqd_checker u_cqd_checker (.*);
